>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the sentence checker RTL.
// Real assertions in simulation; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold at the edge after ante
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> hw/rtl/nmea_pkg.sv
// Types and constants of the NMEA sentence checker.
// Used by nmea_chk_core and nmea_sentence_checker; no dependencies.
package nmea_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_SUM  = 2'd2
  } phase_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam int unsigned ID_LEN       = 5;
  localparam logic [4:0]  FIELD_MAX    = 5'd31;
  localparam logic [39:0] ID_RESET     = 40'h47_50_46_50_44; // "GPFPD"

  // configuration register indexes
  typedef enum logic {
    REG_SENTENCE_ID = 1'b0,
    REG_HDR_ENABLE  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [4:0] field_index;
    logic       in_body;
    logic       sentence_end;
    logic       checksum_ok;
    logic       header_ok;
    logic [7:0] computed_sum;
  } result_t;

endpackage

>>> hw/rtl/nmea_chk_core.sv
// Per-byte sentence state and result logic of the NMEA sentence checker.
// Depends on nmea_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nmea_chk_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,       // consume in_byte this cycle
  input  logic [7:0]            in_byte,
  input  logic [39:0]           expected_id,
  input  logic                  hdr_enable,
  output nmea_pkg::result_t     res
);

  nmea_pkg::phase_t phase, phase_next;
  logic [7:0] running_xor, running_xor_next;
  logic [4:0] field_count, field_count_next;
  logic [2:0] header_position, header_position_next;
  logic       header_match, header_match_next;
  logic [7:0] received_sum, received_sum_next;
  logic [1:0] hex_digit_count, hex_digit_count_next;
  logic       hex_error, hex_error_next;

  logic       eol;
  logic       hex_valid;
  logic [3:0] hex_val;
  logic [7:0] want;
  logic       hdr_result;

  assign eol = (in_byte == nmea_pkg::CH_CR) || (in_byte == nmea_pkg::CH_LF);

  // uppercase hex only
  always_comb begin
    hex_valid = 1'b1;
    hex_val   = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      hex_valid = 1'b0;
    end
  end

  // identifier character expected at this position, first char in top byte
  always_comb begin
    case (header_position)
      3'd0:    want = expected_id[39:32];
      3'd1:    want = expected_id[31:24];
      3'd2:    want = expected_id[23:16];
      3'd3:    want = expected_id[15:8];
      3'd4:    want = expected_id[7:0];
      default: want = 8'h00;
    endcase
  end

  assign hdr_result = !hdr_enable ||
                      (header_match && (header_position == 3'(nmea_pkg::ID_LEN)));

  always_comb begin
    phase_next           = phase;
    running_xor_next     = running_xor;
    field_count_next     = field_count;
    header_position_next = header_position;
    header_match_next    = header_match;
    received_sum_next    = received_sum;
    hex_digit_count_next = hex_digit_count;
    hex_error_next       = hex_error;
    res                  = '0;

    if (in_byte == nmea_pkg::CH_DOLLAR) begin
      // restart, an unfinished sentence is dropped without report
      phase_next           = nmea_pkg::PH_BODY;
      running_xor_next     = 8'd0;
      field_count_next     = 5'd0;
      header_position_next = 3'd0;
      header_match_next    = 1'b1;
      received_sum_next    = 8'd0;
      hex_digit_count_next = 2'd0;
      hex_error_next       = 1'b0;
    end else begin
      unique case (phase)
        nmea_pkg::PH_BODY: begin
          res.field_index = field_count;
          if (eol) begin
            res.sentence_end = 1'b1;
            res.header_ok    = hdr_result;
            phase_next       = nmea_pkg::PH_IDLE;
          end else if (in_byte == nmea_pkg::CH_STAR) begin
            phase_next = nmea_pkg::PH_SUM;
          end else begin
            res.in_body      = 1'b1;
            running_xor_next = running_xor ^ in_byte;
            if (header_position < 3'(nmea_pkg::ID_LEN)) begin
              if (in_byte != want) begin
                header_match_next = 1'b0;
              end
              header_position_next = header_position + 3'd1;
            end
            if (in_byte == nmea_pkg::CH_COMMA && field_count != nmea_pkg::FIELD_MAX) begin
              field_count_next = field_count + 5'd1;
            end
          end
        end
        nmea_pkg::PH_SUM: begin
          res.field_index = field_count;
          if (eol) begin
            res.sentence_end = 1'b1;
            res.checksum_ok  = (hex_digit_count == 2'd2) && !hex_error &&
                               (received_sum == running_xor);
            res.header_ok    = hdr_result;
            phase_next       = nmea_pkg::PH_IDLE;
          end else if (hex_digit_count != 2'd2) begin
            if (!hex_valid) begin
              hex_error_next = 1'b1;
            end else begin
              received_sum_next = {received_sum[3:0], hex_val};
            end
            hex_digit_count_next = hex_digit_count + 2'd1;
          end else begin
            // a third character after the star
            hex_error_next = 1'b1;
          end
        end
        default: begin
          phase_next = nmea_pkg::PH_IDLE;
        end
      endcase
    end
    res.computed_sum = running_xor_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= nmea_pkg::PH_IDLE;
      running_xor     <= 8'd0;
      field_count     <= 5'd0;
      header_position <= 3'd0;
      header_match    <= 1'b1;
      received_sum    <= 8'd0;
      hex_digit_count <= 2'd0;
      hex_error       <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      running_xor     <= running_xor_next;
      field_count     <= field_count_next;
      header_position <= header_position_next;
      header_match    <= header_match_next;
      received_sum    <= received_sum_next;
      hex_digit_count <= hex_digit_count_next;
      hex_error       <= hex_error_next;
    end
  end

  `ASSERT_ALWAYS(a_cok_at_end, clk, rst, !res.checksum_ok || res.sentence_end, "checksum_ok outside sentence end")
  `ASSERT_ALWAYS(a_digits_max, clk, rst, hex_digit_count != 2'd3, "more than two digits counted")
  `ASSERT_ALWAYS(a_pos_max, clk, rst, header_position <= 3'(nmea_pkg::ID_LEN), "header position overrun")
  `ASSERT_NEXT(a_dollar_restart, clk, rst, step && in_byte == nmea_pkg::CH_DOLLAR, phase == nmea_pkg::PH_BODY && running_xor == 8'd0 && field_count == 5'd0, "dollar did not restart sentence")

endmodule

>>> hw/rtl/nmea_sentence_checker.sv
// Top level of the NMEA sentence checker: stream ports, config registers, pipeline.
// Depends on nmea_pkg and nmea_chk_core.
//
// One ASCII byte goes in per item and exactly one result item comes out per
// byte. A '$' starts a sentence; bytes up to '*' are XORed and the first five
// are compared against the configured identifier; commas count fields
// (saturating at 31); after '*' two uppercase hex digits are taken as the sent
// checksum; CR or LF closes the sentence and the result carries sentence_end
// (on tlast), checksum_ok and header_ok. Throughput is one item per clock
// while the result stream is not stalled: the byte is registered, the sentence
// state and the result are worked out combinationally by nmea_chk_core, and the
// result waits in an output register. Configuration writes are always accepted
// (cfg_ready is high) and must only be made while no item is in flight.

module nmea_sentence_checker (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [4:0] field_index, [5] in_body,
                                      // [6] checksum_ok, [7] header_ok,
                                      // [15:8] computed_sum
  output logic        m_axis_tlast,   // sentence_end
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,      // 0 expected_sentence_id, 1 header_check_enable
  input  logic [39:0] cfg_data
);

  logic [39:0]       expected_id;
  logic              hdr_enable;

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              advance;

  nmea_pkg::result_t core_res;
  nmea_pkg::result_t out_res;
  logic              out_valid;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= nmea_pkg::ID_RESET;
      hdr_enable  <= 1'b1;
    end else if (cfg_valid) begin
      unique case (nmea_pkg::cfg_reg_t'(cfg_index))
        nmea_pkg::REG_SENTENCE_ID: expected_id <= cfg_data;
        nmea_pkg::REG_HDR_ENABLE:  hdr_enable  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register: byte moves on once the result register can take its result
  assign advance       = in_valid_q && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  nmea_chk_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .in_byte     (in_byte_q),
    .expected_id (expected_id),
    .hdr_enable  (hdr_enable),
    .res         (core_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_res.sentence_end;
  assign m_axis_tdata  = {out_res.computed_sum, out_res.header_ok, out_res.checksum_ok,
                          out_res.in_body, out_res.field_index};

endmodule

>>> tb/tb.sv
// Self-checking testbench for nmea_sentence_checker: byte stream in, one result item out per byte.
// Depends on nmea_pkg (phase, register and result types) and the nmea_sentence_checker RTL.
// A scoreboard class tracks the sentence state and checks every result field by field.

module tb;

  // Sentence tracker: follows the sentence state byte by byte, queues the
  // result each accepted byte should give and checks results as they arrive.
  class nmea_tracker;
    logic [39:0]       sentence_id;
    logic              hdr_enable;
    nmea_pkg::phase_t  phase;
    logic [7:0]        xor_sum;
    logic [4:0]        fields;
    int unsigned       id_pos;
    logic              id_match;
    logic [7:0]        sent_sum;
    int unsigned       digits;
    logic              digit_bad;
    nmea_pkg::result_t pending[$];
    int unsigned       bytes_taken;
    int unsigned       reports_checked;
    int unsigned       sentences_closed;
    int unsigned       sums_good;
    int unsigned       errors;

    function new();
      sentence_id      = nmea_pkg::ID_RESET;
      hdr_enable       = 1'b1;
      phase            = nmea_pkg::PH_IDLE;
      restart();
      bytes_taken      = 0;
      reports_checked  = 0;
      sentences_closed = 0;
      sums_good        = 0;
      errors           = 0;
    endfunction

    function void restart();
      xor_sum   = '0;
      fields    = '0;
      id_pos    = 0;
      id_match  = 1'b1;
      sent_sum  = '0;
      digits    = 0;
      digit_bad = 1'b0;
    endfunction

    function void set_reg(nmea_pkg::cfg_reg_t idx, logic [39:0] value);
      case (idx)
        nmea_pkg::REG_SENTENCE_ID: sentence_id = value;
        nmea_pkg::REG_HDR_ENABLE:  hdr_enable  = value[0];
      endcase
    endfunction

    function logic hdr_good();
      return !hdr_enable || (id_match && id_pos == nmea_pkg::ID_LEN);
    endfunction

    // uppercase hex only; anything else is a bad digit
    function int nibble_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - "0";
      if (c >= "A" && c <= "F") return int'(c) - "A" + 10;
      return -1;
    endfunction

    function void take_byte(logic [7:0] b);
      nmea_pkg::result_t r;
      logic              eol;
      int                v;
      logic [7:0]        want_ch;
      r   = '0;
      eol = (b == nmea_pkg::CH_CR) || (b == nmea_pkg::CH_LF);
      if (b == nmea_pkg::CH_DOLLAR) begin
        // a dollar always restarts, even mid-sentence
        restart();
        phase = nmea_pkg::PH_BODY;
      end else if (phase == nmea_pkg::PH_BODY) begin
        r.field_index = fields;
        if (eol) begin
          r.sentence_end = 1'b1;
          r.header_ok    = hdr_good();
          phase          = nmea_pkg::PH_IDLE;
        end else if (b == nmea_pkg::CH_STAR) begin
          phase = nmea_pkg::PH_SUM;
        end else begin
          r.in_body = 1'b1;
          xor_sum  ^= b;
          if (id_pos < nmea_pkg::ID_LEN) begin
            want_ch = 8'(sentence_id >> (8 * (nmea_pkg::ID_LEN - 1 - id_pos)));
            if (b != want_ch) id_match = 1'b0;
            id_pos++;
          end
          if (b == nmea_pkg::CH_COMMA && fields != nmea_pkg::FIELD_MAX) fields++;
        end
      end else if (phase == nmea_pkg::PH_SUM) begin
        r.field_index = fields;
        if (eol) begin
          r.sentence_end = 1'b1;
          r.checksum_ok  = (digits == 2) && !digit_bad && (sent_sum == xor_sum);
          r.header_ok    = hdr_good();
          phase          = nmea_pkg::PH_IDLE;
        end else if (digits < 2) begin
          v = nibble_of(b);
          if (v < 0) digit_bad = 1'b1;
          else sent_sum = {sent_sum[3:0], v[3:0]};
          digits++;
        end else begin
          digit_bad = 1'b1;  // third character after the star
        end
      end else begin
        phase = nmea_pkg::PH_IDLE;
      end
      r.computed_sum = xor_sum;
      pending.push_back(r);
      bytes_taken++;
    endfunction

    function void check_report(logic [15:0] data, logic last);
      nmea_pkg::result_t w;
      reports_checked++;
      if (pending.size() == 0) begin
        $error("result item with no byte outstanding: tdata %h tlast %b", data, last);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (data[4:0] !== w.field_index) begin
        $error("field_index: expected %0d, got %0d", w.field_index, data[4:0]);
        errors++;
      end
      if (data[5] !== w.in_body) begin
        $error("in_body: expected %b, got %b", w.in_body, data[5]);
        errors++;
      end
      if (last !== w.sentence_end) begin
        $error("sentence_end: expected %b, got %b", w.sentence_end, last);
        errors++;
      end
      if (data[6] !== w.checksum_ok) begin
        $error("checksum_ok: expected %b, got %b", w.checksum_ok, data[6]);
        errors++;
      end
      if (data[7] !== w.header_ok) begin
        $error("header_ok: expected %b, got %b", w.header_ok, data[7]);
        errors++;
      end
      if (data[15:8] !== w.computed_sum) begin
        $error("computed_sum: expected %h, got %h", w.computed_sum, data[15:8]);
        errors++;
      end
      if (w.sentence_end) begin
        sentences_closed++;
        if (w.checksum_ok) sums_good++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] in_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;    // [4:0] field_index, [5] in_body, [6] checksum_ok,
                                // [7] header_ok, [15:8] computed_sum
  logic        m_axis_tlast;    // sentence_end
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [39:0] cfg_data;

  logic        held;
  nmea_tracker tracker = new();

  nmea_sentence_checker uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Offer one byte; inputs change on the falling edge, acceptance is seen on
  // the rising edge. Valid stays high into the next call unless a gap is drawn.
  // Bytes 500..749 go through with no gaps at all.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ((tracker.bytes_taken < 500 || tracker.bytes_taken >= 750)
           && $urandom_range(0, 99) < 17) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.take_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic write_reg(input nmea_pkg::cfg_reg_t idx, input logic [39:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stop offering and wait for every outstanding result, then let the
  // two-stage pipeline settle.
  task automatic drain();
    int n;
    n = 0;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (tracker.pending.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  // any byte except '$', '*', CR and LF
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(32, 126));
    end while (c == nmea_pkg::CH_DOLLAR || c == nmea_pkg::CH_STAR ||
               c == nmea_pkg::CH_CR || c == nmea_pkg::CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic lower);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (lower ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  // One sentence, mostly well formed with random content; the rest is line
  // noise, wrong or short identifiers, broken checksums and restarts.
  task automatic send_sentence();
    logic [7:0] line[$];
    logic [7:0] acc;
    logic [7:0] c;
    int         n;
    int         nf;
    int         k;
    int         pos;
    logic       lower;
    acc = '0;
    if ($urandom_range(0, 99) < 12) begin
      n = $urandom_range(1, 6);
      repeat (n) line.push_back(8'($urandom_range(0, 255)));
    end else begin
      line.push_back(nmea_pkg::CH_DOLLAR);
      // identifier: exact, one char off, short, or random
      k   = $urandom_range(0, 9);
      n   = (k == 8) ? $urandom_range(0, 4) : nmea_pkg::ID_LEN;
      pos = $urandom_range(0, nmea_pkg::ID_LEN - 1);
      for (int i = 0; i < n; i++) begin
        c = (k == 9) ? body_char()
                     : 8'(tracker.sentence_id >> (8 * (nmea_pkg::ID_LEN - 1 - i)));
        if ((k == 6 || k == 7) && i == pos) c ^= 8'($urandom_range(1, 255));
        line.push_back(c);
        acc ^= c;
      end
      // fields; now and then enough commas to saturate the counter
      nf = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 8);
      if (k == 8 && $urandom_range(0, 1)) nf = 0;
      repeat (nf) begin
        line.push_back(nmea_pkg::CH_COMMA);
        acc ^= nmea_pkg::CH_COMMA;
        n = $urandom_range(0, 6);
        repeat (n) begin
          c = body_char();
          line.push_back(c);
          acc ^= c;
        end
      end
      // dollar mid-sentence: old one dropped, a fresh one starts
      if ($urandom_range(0, 24) == 0) begin
        line.push_back(nmea_pkg::CH_DOLLAR);
        acc = '0;
        n   = $urandom_range(0, 7);
        repeat (n) begin
          c = body_char();
          line.push_back(c);
          acc ^= c;
        end
      end
      // checksum tail: good, wrong, lowercase, one digit, three chars, none, junk
      k     = $urandom_range(0, 19);
      lower = (k == 15);
      if (k != 18) begin
        line.push_back(nmea_pkg::CH_STAR);
        if (k == 14) acc ^= 8'($urandom_range(1, 255));
        if (k == 16) begin
          line.push_back(hex_char(acc[7:4], 1'b0));
        end else if (k == 19) begin
          line.push_back(body_char());
          line.push_back(body_char());
        end else begin
          line.push_back(hex_char(acc[7:4], lower));
          line.push_back(hex_char(acc[3:0], lower));
          if (k == 17) line.push_back(body_char());
        end
      end
      // CR LF, CR alone or LF alone; the LF of a pair arrives while idle
      k = $urandom_range(0, 3);
      if (k != 3) line.push_back(nmea_pkg::CH_CR);
      if (k != 2) line.push_back(nmea_pkg::CH_LF);
    end
    foreach (line[i]) send_byte(line[i]);
  endtask

  // Result side: random back-pressure, one long hold-off early on while the
  // sender keeps going, and a stretch with tready held high.
  initial begin
    m_axis_tready = 1'b0;
    held          = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (!held && tracker.reports_checked >= 150) begin
        held = 1'b1;
        repeat (300) begin
          m_axis_tready = 1'b0;
          @(negedge clk);
        end
      end
      if (tracker.reports_checked >= 900 && tracker.reports_checked < 1150)
        m_axis_tready = 1'b1;
      else
        m_axis_tready = ($urandom_range(0, 99) >= 17);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      tracker.check_report(m_axis_tdata, m_axis_tlast);
  end

  // Watchdog: a time limit far beyond the slowest legal run.
  initial begin
    #400000;
    $display("** nmea_sentence_checker: FAILED **");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = nmea_pkg::REG_SENTENCE_ID;
    cfg_data      = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: byte extremes and CR/LF while idle, a good sentence, a dollar
    // inside a sentence with a short id and no star, lowercase and extra chars.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("\n$GPFPD*45\r$G$,\n$A*0a1\r");

    // Six register settings, the reset one first; the pipeline is drained
    // before each write.
    for (int p = 0; p < 6; p++) begin
      int unsigned target;
      if (p > 0) begin
        drain();
        case (p)
          1: begin
            write_reg(nmea_pkg::REG_SENTENCE_ID, 40'h47_4E_52_4D_43);  // GNRMC
            write_reg(nmea_pkg::REG_HDR_ENABLE, 40'd1);
          end
          2: begin
            write_reg(nmea_pkg::REG_SENTENCE_ID, 40'h0);
            write_reg(nmea_pkg::REG_HDR_ENABLE, 40'd0);
          end
          3: begin
            write_reg(nmea_pkg::REG_SENTENCE_ID, 40'hFF_FFFF_FFFF);
            write_reg(nmea_pkg::REG_HDR_ENABLE, 40'd1);
          end
          4: begin
            write_reg(nmea_pkg::REG_SENTENCE_ID, {8'($urandom), $urandom});
            write_reg(nmea_pkg::REG_HDR_ENABLE, 40'd0);
          end
          default: begin
            write_reg(nmea_pkg::REG_SENTENCE_ID, nmea_pkg::ID_RESET);
            write_reg(nmea_pkg::REG_HDR_ENABLE, 40'd1);
          end
        endcase
      end
      target = tracker.bytes_taken + 230;
      while (tracker.bytes_taken < target) send_sentence();
    end
    drain();

    if (tracker.pending.size() != 0) begin
      $error("%0d results never arrived", tracker.pending.size());
      tracker.errors++;
    end
    $display("Streamed %0d bytes under six register settings: %0d sentences closed,",
             tracker.bytes_taken, tracker.sentences_closed);
    $display("%0d of them with a matching checksum, %0d result items compared.",
             tracker.sums_good, tracker.reports_checked);
    if (tracker.errors == 0) begin
      $display("** nmea_sentence_checker: PASSED **");
    end else begin
      $display("** nmea_sentence_checker: FAILED **");
    end
    $finish;
  end

endmodule
